FILE: rtl/lru_psw_pkg.sv
// shared types and constants for the lru page replacement swap unit
package lru_psw_pkg;

  localparam int DEF_FRAMES     = 8;
  localparam int DEF_SWAP_SLOTS = 64;
  localparam int DEF_PAGE_BITS  = 16;

  // fixed port field widths
  localparam int PAGE_W   = 16;
  localparam int NFRM_W   = 4;
  localparam int SWSZ_W   = 7;
  localparam int FTOT_W   = 32;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [NFRM_W-1:0] RST_NUM_FRAMES = NFRM_W'(8);
  localparam logic [SWSZ_W-1:0] RST_SWAP_SIZE  = SWSZ_W'(64);

  // register index, taken from paddr[2]
  localparam logic REG_NUM_FRAMES = 1'b0;
  localparam logic REG_SWAP_SIZE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FSRCH,
    ST_SSRCH,
    ST_UPD
  } ctrl_state_t;

  typedef struct packed {
    logic start;
    logic fs_step;
    logic sw_start;
    logic sw_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic fs_done;
    logic fs_hit;
    logic full;
    logic sw_done;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: rtl/lru_page_replacement_swap_unit.sv
// lru page replacement with swap store: each request goes through a frame search, a swap search
// on an eviction only, and a commit; the frame search scans one frame per cycle up to the frame count
// the swap search does one swap memory read per cycle, over the entries held in the swap store
// one request in flight; the commit waits while the result register is still full
// rst_n is synchronous: frames and swap store read as empty at once, no clearing pass
module lru_page_replacement_swap_unit import lru_psw_pkg::*; #(
  parameter int FRAMES     = DEF_FRAMES,
  parameter int SWAP_SLOTS = DEF_SWAP_SLOTS,
  parameter int PAGE_BITS  = DEF_PAGE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PAGE_W-1:0] in_page,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_fault,
  output logic              out_evict_valid,
  output logic [PAGE_W-1:0] out_evicted_page,
  output logic              out_swap_written,
  output logic              out_swap_dropped,
  output logic [FTOT_W-1:0] out_fault_total,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [NFRM_W-1:0] num_frames_r;
  logic [SWSZ_W-1:0] swap_size_r;
  logic              cfg_wr;
  dp_cmd_t           cmd;
  dp_sts_t           sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_frames_r <= RST_NUM_FRAMES;
      swap_size_r  <= RST_SWAP_SIZE;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_NUM_FRAMES: num_frames_r <= pwdata[NFRM_W-1:0];
        REG_SWAP_SIZE:  swap_size_r  <= pwdata[SWSZ_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NUM_FRAMES: prdata = {{(APB_DW-NFRM_W){1'b0}}, num_frames_r};
      REG_SWAP_SIZE:  prdata = {{(APB_DW-SWSZ_W){1'b0}}, swap_size_r};
      default:        prdata = '0;
    endcase
  end

  lru_psw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lru_psw_dp #(
    .FRAMES     (FRAMES),
    .SWAP_SLOTS (SWAP_SLOTS),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_page          (in_page),
    .num_frames       (num_frames_r),
    .swap_size        (swap_size_r),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_fault        (out_fault),
    .out_evict_valid  (out_evict_valid),
    .out_evicted_page (out_evicted_page),
    .out_swap_written (out_swap_written),
    .out_swap_dropped (out_swap_dropped),
    .out_fault_total  (out_fault_total)
  );

endmodule

FILE: rtl/lru_psw_ctrl.sv
// sequencer for lookup, swap search and commit of one page request
module lru_psw_ctrl import lru_psw_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_FSRCH;
      end
      ST_FSRCH: begin
        if (sts.fs_done) begin
          if (sts.fs_hit)    state_nxt = ST_UPD;
          else if (sts.full) state_nxt = ST_SSRCH;
          else               state_nxt = ST_UPD;
        end
      end
      ST_SSRCH: begin
        if (sts.sw_done) state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (sts.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_FSRCH: begin
        cmd.fs_step  = 1'b1;
        cmd.sw_start = sts.fs_done && !sts.fs_hit && sts.full;
      end
      ST_SSRCH: begin
        cmd.sw_step = 1'b1;
      end
      ST_UPD: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: rtl/lru_psw_dp.sv
// frame list, swap store, fault counter and result register
module lru_psw_dp import lru_psw_pkg::*; #(
  parameter int FRAMES     = DEF_FRAMES,
  parameter int SWAP_SLOTS = DEF_SWAP_SLOTS,
  parameter int PAGE_BITS  = DEF_PAGE_BITS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [PAGE_W-1:0] in_page,
  input  logic [NFRM_W-1:0] num_frames,
  input  logic [SWSZ_W-1:0] swap_size,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_fault,
  output logic              out_evict_valid,
  output logic [PAGE_W-1:0] out_evicted_page,
  output logic              out_swap_written,
  output logic              out_swap_dropped,
  output logic [FTOT_W-1:0] out_fault_total
);

  localparam int FAW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FCW = $clog2(FRAMES + 1);
  localparam int SAW = (SWAP_SLOTS > 1) ? $clog2(SWAP_SLOTS) : 1;
  localparam int SCW = $clog2(SWAP_SLOTS + 1);
  localparam logic [SCW:0]   SLOTS_X  = (SCW + 1)'(SWAP_SLOTS);
  localparam logic [SAW-1:0] SLOT_TOP = SAW'(SWAP_SLOTS - 1);

  logic [PAGE_BITS-1:0] pg_r;
  logic [PAGE_BITS-1:0] ev_r;

  // frame list, index 0 least recent
  logic [PAGE_BITS-1:0] frm_r   [FRAMES];
  logic [PAGE_BITS-1:0] frm_nxt [FRAMES];
  logic [PAGE_BITS-1:0] frm_up  [FRAMES];
  logic [FCW-1:0]       frm_cnt_r;
  logic [FCW-1:0]       fidx_r;
  logic [FAW-1:0]       pos_r;
  logic                 hit_r;
  logic [FCW-1:0]       flim;
  logic [PAGE_BITS-1:0] frm_rd;
  logic                 fs_match;
  logic                 full;
  logic                 shift_en;
  logic [FCW-1:0]       wr_idx;
  logic [FCW-1:0]       pos_x;

  // swap store
  logic [PAGE_BITS-1:0] swp_mem [SWAP_SLOTS];
  logic [PAGE_BITS-1:0] sw_rd_r;
  logic [SAW-1:0]       head_r;
  logic [SCW-1:0]       scnt_r;
  logic [SAW-1:0]       rp_r;
  logic [SCW-1:0]       iss_r;
  logic [SCW-1:0]       cmpc_r;
  logic                 cmpv_r;
  logic                 found_r;
  logic [SCW-1:0]       slim;
  logic                 sw_issue;
  logic [SCW:0]         wsum;
  logic [SAW-1:0]       waddr;

  logic [FTOT_W-1:0]    ftot_r;
  logic                 evict;
  logic                 written;
  logic                 dropped;

  logic                 out_valid_r;
  logic                 out_fault_r;
  logic                 out_evict_valid_r;
  logic [PAGE_W-1:0]    out_evicted_page_r;
  logic                 out_swap_written_r;
  logic                 out_swap_dropped_r;
  logic [FTOT_W-1:0]    out_fault_total_r;

  // limits with out-of-range settings clamped
  always_comb begin
    if (num_frames == '0)                          flim = FCW'(1);
    else if ({28'd0, num_frames} > 32'(FRAMES))    flim = FCW'(FRAMES);
    else                                           flim = FCW'(num_frames);
    if (swap_size == '0)                           slim = SCW'(1);
    else if ({25'd0, swap_size} > 32'(SWAP_SLOTS)) slim = SCW'(SWAP_SLOTS);
    else                                           slim = SCW'(swap_size);
  end

  assign full     = (frm_cnt_r >= flim);
  assign frm_rd   = frm_r[fidx_r[FAW-1:0]];
  assign fs_match = (fidx_r < frm_cnt_r) && (frm_rd == pg_r);

  for (genvar g = 0; g < FRAMES; g++) begin : g_up
    if (g < FRAMES - 1) begin : g_nb
      assign frm_up[g] = frm_r[g + 1];
    end else begin : g_last
      assign frm_up[g] = frm_r[g];
    end
  end

  // close the gap at pos and put the requested page on the most recent end
  assign evict    = !hit_r && full;
  assign shift_en = hit_r || full;
  assign wr_idx   = shift_en ? (frm_cnt_r - 1'b1) : frm_cnt_r;
  assign pos_x    = hit_r ? FCW'(pos_r) : '0;

  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      if (FCW'(i) == wr_idx)
        frm_nxt[i] = pg_r;
      else if (shift_en && (FCW'(i) >= pos_x) && (FCW'(i + 1) < frm_cnt_r))
        frm_nxt[i] = frm_up[i];
      else
        frm_nxt[i] = frm_r[i];
    end
  end

  assign written = evict && !found_r;
  assign dropped = written && (scnt_r >= slim);
  assign wsum    = (SCW + 1)'(head_r) + (SCW + 1)'(scnt_r);
  assign waddr   = (wsum >= SLOTS_X) ? SAW'(wsum - SLOTS_X) : SAW'(wsum);
  assign sw_issue = cmd.sw_step && (iss_r < scnt_r);

  always_ff @(posedge clk) begin
    if (cmd.start) pg_r <= PAGE_BITS'(in_page);
    if (cmd.sw_start) ev_r <= frm_r[0];
    if (cmd.commit) frm_r <= frm_nxt;
    if (cmd.fs_step && fs_match) pos_r <= fidx_r[FAW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && written) swp_mem[waddr] <= ev_r;
    if (sw_issue) sw_rd_r <= swp_mem[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frm_cnt_r <= '0;
      fidx_r    <= '0;
      hit_r     <= 1'b0;
      head_r    <= '0;
      scnt_r    <= '0;
      rp_r      <= '0;
      iss_r     <= '0;
      cmpc_r    <= '0;
      cmpv_r    <= 1'b0;
      found_r   <= 1'b0;
      ftot_r    <= '0;
    end else begin
      if (cmd.start) begin
        fidx_r <= '0;
        hit_r  <= 1'b0;
      end else if (cmd.fs_step) begin
        if (fs_match)                  hit_r  <= 1'b1;
        else if (fidx_r != frm_cnt_r)  fidx_r <= fidx_r + 1'b1;
      end

      if (cmd.sw_start) begin
        rp_r    <= head_r;
        iss_r   <= '0;
        cmpc_r  <= '0;
        cmpv_r  <= 1'b0;
        found_r <= 1'b0;
      end else if (cmd.sw_step) begin
        // read issued one cycle, compared the next
        cmpv_r <= sw_issue;
        if (sw_issue) begin
          rp_r  <= (rp_r == SLOT_TOP) ? '0 : rp_r + 1'b1;
          iss_r <= iss_r + 1'b1;
        end
        if (cmpv_r) begin
          cmpc_r <= cmpc_r + 1'b1;
          if (sw_rd_r == ev_r) found_r <= 1'b1;
        end
      end

      if (cmd.commit) begin
        if (!shift_en) frm_cnt_r <= frm_cnt_r + 1'b1;
        if (!hit_r && (ftot_r != '1)) ftot_r <= ftot_r + 1'b1;
        if (dropped) head_r <= (head_r == SLOT_TOP) ? '0 : head_r + 1'b1;
        if (written && !dropped) scnt_r <= scnt_r + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_fault_r        <= !hit_r;
      out_evict_valid_r  <= evict;
      out_evicted_page_r <= evict ? PAGE_W'(ev_r) : '0;
      out_swap_written_r <= written;
      out_swap_dropped_r <= dropped;
      out_fault_total_r  <= (!hit_r && (ftot_r != '1)) ? ftot_r + 1'b1 : ftot_r;
    end
  end

  assign sts.fs_done  = fs_match || (fidx_r == frm_cnt_r);
  assign sts.fs_hit   = fs_match;
  assign sts.full     = full;
  assign sts.sw_done  = found_r || (cmpc_r == scnt_r);
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_fault        = out_fault_r;
  assign out_evict_valid  = out_evict_valid_r;
  assign out_evicted_page = out_evicted_page_r;
  assign out_swap_written = out_swap_written_r;
  assign out_swap_dropped = out_swap_dropped_r;
  assign out_fault_total  = out_fault_total_r;

  a_frm_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    frm_cnt_r <= FCW'(FRAMES))
    else $error("frame count above frame capacity");

  a_swp_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    scnt_r <= SCW'(SWAP_SLOTS))
    else $error("swap count above swap capacity");

  a_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_evict_valid_r |->
      (out_evicted_page_r == '0) && !out_swap_written_r && !out_swap_dropped_r)
    else $error("swap activity without an eviction");

  a_drop_wr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_swap_dropped_r |-> out_swap_written_r && out_fault_r)
    else $error("swap drop without an append on a fault");

  a_ftot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> ftot_r >= $past(ftot_r))
    else $error("fault counter went backwards");

endmodule

FILE: tb/tb_lru_page_replacement_swap_unit.sv
// testbench for the lru page replacement swap unit: directed and random requests, self-checking
`timescale 1ns / 100ps

module tb_lru_page_replacement_swap_unit;
  import lru_psw_pkg::*;

  localparam int LONG_HOLD   = 500;
  localparam int PHASE_ITEMS = 160;

  typedef struct packed {
    logic              fault;
    logic              evict_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic              swap_written;
    logic              swap_dropped;
    logic [FTOT_W-1:0] fault_total;
  } outcome_t;

  // recency order and swap fifo kept as queues, index 0 is least recent / oldest
  class replacement_tracker;
    logic [PAGE_W-1:0] frames[$];
    logic [PAGE_W-1:0] swapped[$];
    logic [FTOT_W-1:0] faults;
    logic [NFRM_W-1:0] nfrm;
    logic [SWSZ_W-1:0] swsz;
    outcome_t          due[$];
    int                mismatch_count;

    function new();
      faults = '0;
      nfrm = RST_NUM_FRAMES;
      swsz = RST_SWAP_SIZE;
      mismatch_count = 0;
    endfunction

    function void set_reg(logic idx, logic [APB_DW-1:0] val);
      if (idx == REG_NUM_FRAMES) nfrm = val[NFRM_W-1:0];
      else swsz = val[SWSZ_W-1:0];
    endfunction

    function int pending();
      return due.size();
    endfunction

    function outcome_t predict_request(logic [PAGE_W-1:0] pg);
      outcome_t    o;
      int          pos;
      int unsigned flim;
      int unsigned slim;
      bit          held;
      o = '0;
      pos = -1;
      held = 1'b0;
      flim = (nfrm == 0) ? 1 : ((nfrm > DEF_FRAMES) ? DEF_FRAMES : nfrm);
      slim = (swsz == 0) ? 1 : ((swsz > DEF_SWAP_SLOTS) ? DEF_SWAP_SLOTS : swsz);
      foreach (frames[i]) if (pos < 0 && frames[i] == pg) pos = i;
      if (pos >= 0) begin
        frames.delete(pos);
      end else begin
        o.fault = 1'b1;
        if (faults != '1) faults++;
        // a lowered limit still evicts just one page per miss
        if (frames.size() >= flim) begin
          o.evict_valid = 1'b1;
          o.evicted_page = frames[0];
          foreach (swapped[j]) if (swapped[j] == frames[0]) held = 1'b1;
          if (!held) begin
            if (swapped.size() >= slim) begin
              o.swap_dropped = 1'b1;
              swapped.delete(0);
            end
            swapped.insert(swapped.size(), frames[0]);
            o.swap_written = 1'b1;
          end
          frames.delete(0);
        end
      end
      if (frames.size() < DEF_FRAMES) frames.insert(frames.size(), pg);
      o.fault_total = faults;
      return o;
    endfunction

    function void note_request(logic [PAGE_W-1:0] pg);
      due.insert(due.size(), predict_request(pg));
    endfunction

    task report(string what, logic [FTOT_W-1:0] got, logic [FTOT_W-1:0] want);
      mismatch_count++;
      $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
    endtask

    task check_outcome(outcome_t got);
      outcome_t want;
      if (due.size() == 0) begin
        report("unexpected result", got.fault_total, '0);
        return;
      end
      want = due[0];
      due.delete(0);
      if (got.fault !== want.fault)
        report("fault", FTOT_W'(got.fault), FTOT_W'(want.fault));
      if (got.evict_valid !== want.evict_valid)
        report("evict_valid", FTOT_W'(got.evict_valid), FTOT_W'(want.evict_valid));
      if (got.evicted_page !== want.evicted_page)
        report("evicted_page", FTOT_W'(got.evicted_page), FTOT_W'(want.evicted_page));
      if (got.swap_written !== want.swap_written)
        report("swap_written", FTOT_W'(got.swap_written), FTOT_W'(want.swap_written));
      if (got.swap_dropped !== want.swap_dropped)
        report("swap_dropped", FTOT_W'(got.swap_dropped), FTOT_W'(want.swap_dropped));
      if (got.fault_total !== want.fault_total)
        report("fault_total", got.fault_total, want.fault_total);
    endtask
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PAGE_W-1:0] in_page = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_fault;
  logic              out_evict_valid;
  logic [PAGE_W-1:0] out_evicted_page;
  logic              out_swap_written;
  logic              out_swap_dropped;
  logic [FTOT_W-1:0] out_fault_total;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  replacement_tracker board = new();

  int in_idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_taken = 0;
  int hold_left = 0;

  lru_page_replacement_swap_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_page          (in_page),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_fault        (out_fault),
    .out_evict_valid  (out_evict_valid),
    .out_evicted_page (out_evicted_page),
    .out_swap_written (out_swap_written),
    .out_swap_dropped (out_swap_dropped),
    .out_fault_total  (out_fault_total),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: check each transfer, then decide ready for the next edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_outcome({out_fault, out_evict_valid, out_evicted_page,
                           out_swap_written, out_swap_dropped, out_fault_total});
    if (hold_asked != hold_taken) begin
      hold_taken = hold_asked;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_page(input logic [PAGE_W-1:0] pg);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_page <= pg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_request(pg);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [APB_DW-1:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_limits(input int nf, input int sw);
    settle_block();
    write_reg(REG_NUM_FRAMES, APB_DW'(nf));
    write_reg(REG_SWAP_SIZE, APB_DW'(sw));
  endtask

  initial begin
    logic [PAGE_W-1:0] pool[$];
    logic [PAGE_W-1:0] pg;
    int                nf;
    int                sw;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limits: fill all eight frames, then one eviction
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'hAAAA);
    send_page(16'h5555);
    send_page(16'h0000);
    send_page(16'h0001);
    send_page(16'h0002);
    send_page(16'h0003);
    send_page(16'h0004);
    send_page(16'h0005);
    // limits lowered below the fill, one-slot swap store
    set_limits(2, 1);
    send_page(16'h0006);
    send_page(16'h5555);
    send_page(16'h0007);
    send_page(16'h0000);
    // zero limits act as one
    set_limits(0, 0);
    send_page(16'h0008);
    send_page(16'h0008);
    send_page(16'h0009);
    // limits above the sizes act as the sizes
    set_limits(15, 127);
    send_page(16'h8000);
    send_page(16'h7FFF);
    send_page(16'h0009);

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin nf = 1;  sw = 1;   end
        1: begin nf = 8;  sw = 64;  end
        2: begin nf = 4;  sw = 3;   end
        3: begin nf = 0;  sw = 0;   end
        4: begin nf = 15; sw = 127; end
        5: begin nf = 2;  sw = 8;   end
        6: begin nf = 3;  sw = 65;  end
        default: begin
          nf = $urandom_range(1, DEF_FRAMES);
          sw = $urandom_range(1, DEF_SWAP_SLOTS);
        end
      endcase
      set_limits(nf, sw);
      case (p % 4)
        0: begin in_idle_pct = 0;  stall_pct <= 0;  end
        1: begin in_idle_pct = 77; stall_pct <= 0;  end
        2: begin in_idle_pct = 0;  stall_pct <= 77; end
        default: begin in_idle_pct = 25; stall_pct <= 25; end
      endcase
      // small working set gives hits and swap re-evictions, fresh pages fill the swap
      pool.delete();
      repeat ($urandom_range(2, 16)) pool.insert(pool.size(), PAGE_W'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 4 && n == 20) hold_asked <= hold_asked + 1;
        if ($urandom_range(99) < 15) pg = PAGE_W'($urandom);
        else pg = pool[$urandom_range(pool.size() - 1)];
        send_page(pg);
      end
    end

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("timeout waiting for results");
    $display("end of test: mismatches");
    $finish;
  end

endmodule
